// ===== src/mbps_pkg.sv =====
// Package for the masked byte pattern scan block.
// Holds shared widths, register indexes and the result item type.
// No dependencies.
package mbps_pkg;

   localparam int CFG_PATTERN_BYTES = 16;   // pattern bytes held in the two config words
   localparam int LEN_W             = 5;
   localparam int OUT_OFFSET_W      = 32;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 64;
   localparam int BYTE_W            = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CARE_MASK    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LEN  = 2'd3;

   typedef struct packed {
      logic                    found;
      logic [OUT_OFFSET_W-1:0] match_offset;
   } result_type;

   typedef struct packed {
      logic advance;   // an item is taken this cycle
      logic restart;   // that item ends the region
   } cell_ctrl_type;

endpackage

// ===== src/mbps_cell.sv =====
// One match cell: tracks whether pattern bytes 0..j matched the bytes ending at
// the newest one. Takes the partial-match flag of its left neighbor. Uses mbps_pkg.
module mbps_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  mbps_pkg::cell_ctrl_type     ctrl,
   input  logic [mbps_pkg::BYTE_W-1:0] data_byte,
   input  logic [mbps_pkg::BYTE_W-1:0] pattern_byte,
   input  logic                        care,
   input  logic                        prev_flag,
   output logic                        flag,
   output logic                        match_now
);
   import mbps_pkg::*;

   logic flag_ff;
   logic flag_in;

   // prev_flag is the left cell's state from the previous byte
   assign match_now = prev_flag && (!care || (data_byte == pattern_byte));

   always_comb begin
      flag_in = flag_ff;
      if (ctrl.advance) begin
         flag_in = ctrl.restart ? 1'b0 : match_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flag_ff <= 1'b0;
      end else begin
         flag_ff <= flag_in;
      end
   end

   assign flag = flag_ff;

endmodule

// ===== src/mbps_out_q.sv =====
// Two-entry result queue between the scan logic and the result channel.
// Lets the block keep taking items while a result waits. Uses mbps_pkg.
module mbps_out_q (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mbps_pkg::result_type push_data,
   output logic                 can_push,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mbps_pkg::result_type out_data
);
   import mbps_pkg::*;

   result_type slot_ff [2];
   result_type slot_in [2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;
   logic [1:0] wpos;

   assign pop       = out_valid && out_ready;
   assign out_valid = (count_ff != 2'd0);
   assign can_push  = (count_ff != 2'd2);
   assign out_data  = slot_ff[0];
   assign wpos      = count_ff - {1'b0, pop};

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      if (pop) begin
         slot_in[0] = slot_ff[1];
      end
      if (push) begin
         if (wpos == 2'd0) begin
            slot_in[0] = push_data;
         end else begin
            slot_in[1] = push_data;
         end
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== src/masked_byte_pattern_scan_top.sv =====
// Top level of the masked byte pattern scan: config registers, the row of
// match cells, offset counter and result queue. Uses mbps_pkg, mbps_cell, mbps_out_q.
//
//  channel | ports                           | payload
//  --------+---------------------------------+-----------------------------------
//  input   | req_tvalid/tready/tdata/tlast   | tdata[7:0] data_byte, tlast last_byte
//  result  | rsp_tvalid/tready/tdata/tuser   | tuser found, tdata[31:0] match_offset
//  config  | csr_valid/ready/index/data      | index 0..3 selects register, data 64b
//
// One item per cycle while the output queue has room; the whole cell row updates on each
// taken byte, and a result (if any) enters the output queue in that same cycle.
// The result of the byte that completes the window or ends the region is registered in the output queue.
// Reset is synchronous: cells, counter, match flag, queue and registers clear.
// req_tready drops only while both output queue entries are full.
// csr_ready is always high; the user must write registers only while the block is idle (not enforced).
module masked_byte_pattern_scan_top #(
   parameter int MAX_PATTERN = 16,
   parameter int OFFSET_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] data_byte
   input  logic                              req_tlast,   // last_byte
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mbps_pkg::OUT_OFFSET_W-1:0] rsp_tdata,   // [31:0] match_offset
   output logic                              rsp_tuser,   // [0] found
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mbps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]   csr_data
);
   import mbps_pkg::*;

   logic [CSR_DATA_W-1:0]        pat_low_ff, pat_high_ff;
   logic [CFG_PATTERN_BYTES-1:0] care_ff;
   logic [LEN_W-1:0]             len_ff;

   logic [OFFSET_BITS-1:0] bytes_seen_ff, bytes_seen_in;
   logic [OFFSET_BITS-1:0] taken, off;
   logic                   done_ff, done_in;

   logic                         accept;
   cell_ctrl_type                ctrl;
   logic [2*CSR_DATA_W-1:0]      pat_all;
   logic [MAX_PATTERN-1:0]       flags;
   logic [MAX_PATTERN-1:0]       match_now;
   logic                         len_hit;
   logic                         hit;
   logic                         push;
   logic                         can_push;
   result_type                   push_data;
   result_type                   out_data;
   logic [OUT_OFFSET_W-1:0]      off_out;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         care_ff     <= '0;
         len_ff      <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pat_low_ff  <= csr_data;
            CSR_PATTERN_HIGH: pat_high_ff <= csr_data;
            CSR_CARE_MASK:    care_ff     <= csr_data[CFG_PATTERN_BYTES-1:0];
            CSR_PATTERN_LEN:  len_ff      <= csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign accept       = req_tvalid && req_tready;
   assign req_tready   = can_push;
   assign pat_all      = {pat_high_ff, pat_low_ff};

   always_comb begin
      ctrl.advance = accept;
      ctrl.restart = req_tlast;
   end

   // cell row; bytes beyond the configured sixteen are wildcards
   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      logic [BYTE_W-1:0] pbyte;
      logic              pcare;
      logic              prev;
      if (j < CFG_PATTERN_BYTES) begin : g_cfg
         assign pbyte = pat_all[BYTE_W*j +: BYTE_W];
         assign pcare = care_ff[j];
      end else begin : g_wild
         assign pbyte = '0;
         assign pcare = 1'b0;
      end
      if (j == 0) begin : g_first
         assign prev = 1'b1;
      end else begin : g_next
         assign prev = flags[j-1];
      end
      mbps_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .data_byte    (req_tdata),
         .pattern_byte (pbyte),
         .care         (pcare),
         .prev_flag    (prev),
         .flag         (flags[j]),
         .match_now    (match_now[j])
      );
   end

   // zero length and lengths past the row never select a cell
   always_comb begin
      len_hit = 1'b0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         if ((32'(len_ff) == j + 1) && match_now[j]) begin
            len_hit = 1'b1;
         end
      end
   end

   assign taken = bytes_seen_ff + 1'b1;
   assign off   = taken - {{(OFFSET_BITS-LEN_W){1'b0}}, len_ff};
   assign hit   = accept && !done_ff && len_hit;
   assign push  = hit || (accept && req_tlast && !done_ff);

   if (OFFSET_BITS >= OUT_OFFSET_W) begin : g_off_trunc
      assign off_out = off[OUT_OFFSET_W-1:0];
   end else begin : g_off_ext
      assign off_out = {{(OUT_OFFSET_W-OFFSET_BITS){1'b0}}, off};
   end

   always_comb begin
      push_data.found        = hit;
      push_data.match_offset = hit ? off_out : '0;
   end

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      done_in       = done_ff;
      if (accept) begin
         if (req_tlast) begin
            bytes_seen_in = '0;
            done_in       = 1'b0;
         end else begin
            bytes_seen_in = taken;
            done_in       = done_ff || hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         done_ff       <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         done_ff       <= done_in;
      end
   end

   mbps_out_q u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .can_push  (can_push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tuser = out_data.found;
   assign rsp_tdata = out_data.match_offset;

   // stalling the input only happens with results pending
   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with empty result queue");

   // end of region restarts the scan
   a_region_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tlast) |=> (!done_ff && bytes_seen_ff == '0 && flags == '0))
      else $error("scan state not cleared after last byte");

   // only one match per region
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tlast && done_ff) |=> done_ff)
      else $error("match flag dropped inside a region");

endmodule

// ===== bench/mbps_scan_checker.sv =====
// Checker for the masked byte pattern scan: watches the config, input and result
// channels, predicts each scan outcome and compares it with what the block returns.
// Depends on mbps_pkg.
module mbps_scan_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [mbps_pkg::BYTE_W-1:0]       req_tdata,    // [7:0] data_byte
   input  logic                              req_tlast,    // last_byte
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [mbps_pkg::OUT_OFFSET_W-1:0] rsp_tdata,    // [31:0] match_offset
   input  logic                              rsp_tuser,    // [0] found
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [mbps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]   csr_data,
   output int                                failures,
   output int                                pending,
   output int                                hits_seen,
   output int                                misses_seen
);
   timeunit 1ns;
   timeprecision 1ps;
   import mbps_pkg::*;

   localparam int WINDOW     = CFG_PATTERN_BYTES;
   localparam int PRINT_CAP  = 50;

   logic [8*WINDOW-1:0]     pattern;        // {high word, low word}
   logic [WINDOW-1:0]       care;
   logic [LEN_W-1:0]        span;
   logic [BYTE_W-1:0]       recent [WINDOW]; // entry 0 is the newest byte
   logic [OUT_OFFSET_W-1:0] region_count;
   logic                    reported;
   int                      fill;
   result_type              awaited_results [$];

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      failures++;
      if (failures <= PRINT_CAP)
         $display("check: %s mismatch at %0t, expected %0h, got %0h", what, $realtime,
                  want, got);
   endtask

   function automatic void clear_scan();
      foreach (recent[i]) recent[i] = '0;
      region_count = '0;
      reported     = 1'b0;
      fill         = 0;
   endfunction

   function automatic void await_result(input result_type r);
      awaited_results.insert(awaited_results.size(), r);
   endfunction

   function automatic logic window_hit();
      int n;
      n = span;
      // pattern byte i lines up with the byte that arrived n-1-i items ago
      for (int i = 0; i < n; i++)
         if (care[i] && recent[n-1-i] != pattern[8*i +: 8]) return 1'b0;
      return 1'b1;
   endfunction

   task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic fin);
      result_type              outcome;
      logic [OUT_OFFSET_W-1:0] taken;
      for (int i = WINDOW - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = b;
      if (fill < WINDOW) fill++;
      taken = region_count + 1'b1;
      if (!reported && span != 0 && span <= WINDOW && fill >= span && window_hit()) begin
         outcome.found        = 1'b1;
         outcome.match_offset = taken - span;
         await_result(outcome);
         reported = 1'b1;
      end
      if (fin) begin
         if (!reported) begin
            outcome.found        = 1'b0;
            outcome.match_offset = '0;
            await_result(outcome);
         end
         clear_scan();
      end else begin
         region_count = taken;
      end
   endtask

   task automatic check_result();
      result_type want;
      if (awaited_results.size() == 0) begin
         report_mismatch("unawaited result, offset", 0, rsp_tdata);
         return;
      end
      want = awaited_results.pop_front();
      if (rsp_tuser != want.found)
         report_mismatch("found flag", want.found, rsp_tuser);
      if (rsp_tdata != want.match_offset)
         report_mismatch("match offset", want.match_offset, rsp_tdata);
      if (want.found) hits_seen++;
      else misses_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pattern = '0;
         care    = '0;
         span    = '0;
         clear_scan();
         awaited_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PATTERN_LOW:  pattern[CSR_DATA_W-1:0] = csr_data;
               CSR_PATTERN_HIGH: pattern[2*CSR_DATA_W-1:CSR_DATA_W] = csr_data;
               CSR_CARE_MASK:    care = csr_data[WINDOW-1:0];
               CSR_PATTERN_LEN:  span = csr_data[LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) scan_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      pending <= awaited_results.size();
   end

endmodule

// ===== bench/masked_byte_pattern_scan_top_tb.sv =====
// Testbench top for the masked byte pattern scan: clock, reset, config writes,
// directed and random byte regions with idling and back-pressure, and the verdict.
// Depends on mbps_pkg, masked_byte_pattern_scan_top and mbps_scan_checker.
module masked_byte_pattern_scan_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mbps_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 11;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 200;
   localparam int PHASE_ITEMS  = 200;
   localparam int WINDOW       = CFG_PATTERN_BYTES;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [BYTE_W-1:0]       req_tdata  = '0;
   logic                    req_tlast  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [OUT_OFFSET_W-1:0] rsp_tdata;
   logic                    rsp_tuser;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_data   = '0;

   int failures, pending, hits_seen, misses_seen;
   int cycles        = 0;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int hold_asked    = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int items_sent    = 0;
   int settings_used = 0;

   // copy of the programmed pattern, used to plant matches in a region
   logic [8*WINDOW-1:0] cur_pattern = '0;
   logic [WINDOW-1:0]   cur_care    = '0;
   int                  cur_len     = 0;
   logic [BYTE_W-1:0]   region_bytes [$];

   masked_byte_pattern_scan_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   mbps_scan_checker scan_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .failures    (failures),
      .pending     (pending),
      .hits_seen   (hits_seen),
      .misses_seen (misses_seen)
   );

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_asked != hold_served) begin
         hold_served <= hold_asked;
         hold_left   <= HOLD_CYCLES;
         rsp_tready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_item(input logic [BYTE_W-1:0] b, input logic fin);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // stop offering, let every awaited result arrive, then stay quiet a while longer
   // since the last byte may have caused no result at all
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_pattern(input logic [CSR_DATA_W-1:0] lo,
                                  input logic [CSR_DATA_W-1:0] hi,
                                  input logic [WINDOW-1:0] care_bits,
                                  input logic [LEN_W-1:0] len);
      settle();
      write_reg(CSR_PATTERN_LOW, lo);
      write_reg(CSR_PATTERN_HIGH, hi);
      write_reg(CSR_CARE_MASK, CSR_DATA_W'(care_bits));
      write_reg(CSR_PATTERN_LEN, CSR_DATA_W'(len));
      csr_valid   <= 1'b0;
      cur_pattern  = {hi, lo};
      cur_care     = care_bits;
      cur_len      = len;
      settings_used++;
   endtask

   function automatic void plant(input int at);
      for (int j = 0; j < cur_len; j++)
         if (cur_care[j]) region_bytes[at + j] = cur_pattern[8*j +: 8];
   endfunction

   function automatic void add_region_byte(input logic [BYTE_W-1:0] b);
      region_bytes.insert(region_bytes.size(), b);
   endfunction

   task automatic send_region(input int n, input int first_at, input int second_at,
                              input bit spoil);
      region_bytes.delete();
      repeat (n) add_region_byte(BYTE_W'($urandom_range(255)));
      if (first_at >= 0) plant(first_at);
      if (second_at >= 0) plant(second_at);
      // broken copy: one byte of the first planted window disturbed
      if (spoil)
         region_bytes[first_at + $urandom_range(cur_len - 1)] ^= BYTE_W'($urandom_range(255, 1));
      foreach (region_bytes[k]) send_item(region_bytes[k], k == n - 1);
   endtask

   task automatic random_setting();
      logic [CSR_DATA_W-1:0] lo, hi;
      logic [WINDOW-1:0]     mask;
      logic [LEN_W-1:0]      len;
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      case ($urandom_range(7))
         0: lo = '1;
         1: hi = '0;
         default: ;
      endcase
      case ($urandom_range(4))
         0: mask = '0;
         1: mask = '1;
         default: mask = WINDOW'($urandom);
      endcase
      case ($urandom_range(11))
         0:       len = '0;
         1:       len = LEN_W'(WINDOW);
         2:       len = LEN_W'($urandom_range(31, WINDOW + 1));
         3, 4:    len = LEN_W'($urandom_range(WINDOW - 1, 9));
         default: len = LEN_W'($urandom_range(8, 1));
      endcase
      program_pattern(lo, hi, mask, len);
   endtask

   task automatic random_region();
      int n, kind, at;
      n    = ($urandom_range(9) == 0) ? $urandom_range(80, 21) : $urandom_range(20, 1);
      kind = $urandom_range(99);
      if (cur_len == 0 || cur_len > WINDOW || n < cur_len || kind >= 85) begin
         send_region(n, -1, -1, 1'b0);
      end else begin
         at = $urandom_range(n - cur_len);
         send_region(n, at, (kind < 10) ? $urandom_range(n - cur_len) : -1, kind >= 70);
      end
   endtask

   initial begin
      int phase_end;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 35;
      rsp_idle_pct  = 81;

      // registers still at reset: zero length never matches
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b1);
      // full-width pattern completed by the region's last byte
      program_pattern('0, '1, '1, LEN_W'(WINDOW));
      send_region(WINDOW, 0, -1, 1'b0);
      // length beyond the window never matches, even on all-ones bytes
      program_pattern('1, '0, '1, 5'd31);
      send_item(8'hFF, 1'b0);
      send_item(8'hFF, 1'b1);
      // wildcards only: short region misses, longer one hits and then goes quiet
      program_pattern('0, '0, '0, 5'd2);
      send_item(8'h5A, 1'b1);
      send_item(8'hA5, 1'b0);
      send_item(8'h3C, 1'b0);
      send_item(8'hC3, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 35; rsp_idle_pct = 81; end
            1:       begin send_idle_pct = 81; rsp_idle_pct = 35; end
            default: begin send_idle_pct = 0;  rsp_idle_pct = 0;  end
         endcase
         if (phase == 2) begin
            // every one-byte region yields a result; hold the receiver so the
            // output queue fills and the input stalls
            program_pattern('0, '0, '0, 5'd1);
            hold_asked++;
            repeat (40) send_item(BYTE_W'($urandom), 1'b1);
            settle();
         end
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            random_setting();
            repeat ($urandom_range(6, 2)) random_region();
         end
      end

      settle();
      $display("tb: %0d bytes scanned under %0d pattern settings", items_sent, settings_used);
      $display("tb: %0d match and %0d not-found results checked", hits_seen, misses_seen);
      if (failures == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
